// ===== rtl/core/pfci_pkg.sv =====
// Shared types and constants for the paged flash command interface.
`default_nettype none

package pfci_pkg;

    // Command sequencer states (JEDEC unlock / command flow)
    typedef enum logic [3:0] {
        CMD_IDLE          = 4'd0,
        CMD_UNLOCK1       = 4'd1,
        CMD_COMMAND       = 4'd2,
        CMD_PROGRAM       = 4'd3,
        CMD_ERASE_UNLOCK1 = 4'd4,
        CMD_ERASE_UNLOCK2 = 4'd5,
        CMD_ERASE_CMD     = 4'd6,
        CMD_AUTOSELECT    = 4'd7
    } cmd_state_t;

    // Memory sequencer states
    typedef enum logic [2:0] {
        SEQ_SWEEP = 3'd0,
        SEQ_FIND  = 3'd1,
        SEQ_RUN   = 3'd2,
        SEQ_READ  = 3'd3,
        SEQ_PROG  = 3'd4
    } seq_state_t;

    // Actions that a command write starts
    typedef struct packed {
        logic prog;
        logic chip_erase;
        logic sector_erase;
    } cmd_act_t;

    // Command decode sees only the low offset bits
    localparam int CMD_OFF_W = 11;

    localparam logic [CMD_OFF_W-1:0] CMD_ADDR_A = 11'h555;
    localparam logic [CMD_OFF_W-1:0] CMD_ADDR_B = 11'h2AA;

    localparam logic [7:0] DATA_UNLOCK1  = 8'hAA;
    localparam logic [7:0] DATA_UNLOCK2  = 8'h55;
    localparam logic [7:0] DATA_PROGRAM  = 8'hA0;
    localparam logic [7:0] DATA_ERASE    = 8'h80;
    localparam logic [7:0] DATA_AUTOSEL  = 8'h90;
    localparam logic [7:0] DATA_CHIP     = 8'h10;
    localparam logic [7:0] DATA_SECTOR   = 8'h30;
    localparam logic [7:0] DATA_RESET    = 8'hF0;

    localparam logic [7:0] ID_MFR        = 8'h01;
    localparam logic [7:0] ID_DEV        = 8'h20;
    localparam logic [7:0] ID_NONE       = 8'h00;
    localparam logic [7:0] ERASED_BYTE   = 8'hFF;

endpackage

`default_nettype wire

// ===== rtl/core/pfci_store.sv =====
// Byte-wide flash array: one write port, one registered read port.
`default_nettype none

module pfci_store #(
    parameter int DEPTH  = 131072,
    parameter int ADDR_W = 17
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pfci_cmd.sv =====
// JEDEC command sequencer: unlock tracking and command decode.
`default_nettype none

module pfci_cmd (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            wr_fire,
    input  wire logic [pfci_pkg::CMD_OFF_W-1:0]  cmd_off,
    input  wire logic [7:0]                      data,
    output pfci_pkg::cmd_state_t                 state,
    output pfci_pkg::cmd_act_t                   act
);

    import pfci_pkg::*;

    cmd_state_t state_reg, state_next;

    logic at_a, at_b;
    assign at_a = (cmd_off == CMD_ADDR_A);
    assign at_b = (cmd_off == CMD_ADDR_B);

    // next command state
    always_comb begin
        state_next = state_reg;
        if (wr_fire) begin
            if (data == DATA_RESET) begin
                state_next = CMD_IDLE;
            end else begin
                case (state_reg)
                    CMD_IDLE: begin
                        if (at_a && data == DATA_UNLOCK1) state_next = CMD_UNLOCK1;
                    end
                    CMD_UNLOCK1: begin
                        state_next = (at_b && data == DATA_UNLOCK2) ? CMD_COMMAND : CMD_IDLE;
                    end
                    CMD_COMMAND: begin
                        if (at_a && data == DATA_PROGRAM)      state_next = CMD_PROGRAM;
                        else if (at_a && data == DATA_ERASE)   state_next = CMD_ERASE_UNLOCK1;
                        else if (at_a && data == DATA_AUTOSEL) state_next = CMD_AUTOSELECT;
                        else                                   state_next = CMD_IDLE;
                    end
                    CMD_ERASE_UNLOCK1: begin
                        state_next = (at_a && data == DATA_UNLOCK1) ? CMD_ERASE_UNLOCK2
                                                                    : CMD_IDLE;
                    end
                    CMD_ERASE_UNLOCK2: begin
                        state_next = (at_b && data == DATA_UNLOCK2) ? CMD_ERASE_CMD : CMD_IDLE;
                    end
                    default: begin
                        // erase command, program, autoselect: one write and done
                        state_next = CMD_IDLE;
                    end
                endcase
            end
        end
    end

    // actions started by this write
    always_comb begin
        act = '0;
        if (wr_fire && data != DATA_RESET) begin
            case (state_reg)
                CMD_PROGRAM: begin
                    act.prog = 1'b1;
                end
                CMD_ERASE_CMD: begin
                    if (at_a && data == DATA_CHIP) act.chip_erase = 1'b1;
                    else if (data == DATA_SECTOR)  act.sector_erase = 1'b1;
                end
                default: begin
                    act = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CMD_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire

// ===== rtl/core/paged_flash_command_interface.sv =====
// Paged flash command interface: a byte-wide NOR flash behind a JEDEC command sequencer.
//
// Input channel s_*: one word per bus access. s_operation 0 reads a byte, 1 writes one.
// s_flash_page selects the page for a paged window; s_fixed_window maps page 0 and
// decodes the full offset for ID reads. Result channel m_*: one word per read, none
// for writes.
// Paths: a read goes through the memory read register, then the output register; a
// plain or command write needs no further sequencer state; a program write reads the
// byte, then ANDs and writes it back, the following access waiting for it in the sequencer.
// Erases walk the array one byte per cycle: a chip erase sweeps the whole array; a sector
// erase first steps down one sector at a time to find the sector base, then sweeps the
// pages of that sector. s_ready is low meanwhile.
// Reset: the command state goes idle and the same sweep fills the whole array with FF
// before the first word is taken.
// Stalls: a result sits in the output register until m_ready; writes and further
// reads are taken as long as the output register is free or drains in that cycle.
`default_nettype none

module paged_flash_command_interface #(
    parameter int PAGE_BYTES       = 4096,
    parameter int PAGE_COUNT       = 32,
    parameter int PAGES_PER_SECTOR = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [4:0]  s_flash_page,
    input  wire logic [11:0] s_page_offset,
    input  wire logic [7:0]  s_write_byte,
    input  wire logic        s_fixed_window,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_read_byte
);

    import pfci_pkg::*;

    localparam int STORE_BYTES = PAGE_COUNT * PAGE_BYTES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int AW1         = ADDR_W + 1;
    localparam int PAGE_W      = $clog2(PAGE_COUNT);
    localparam int OFF_W       = $clog2(PAGE_BYTES);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    // ------------------------------------------------------------------
    // address mapping
    logic [8:0]        page_wrap;
    logic [PAGE_W-1:0] eff_page;
    logic [16:0]       off_wrap;
    logic [OFF_W-1:0]  eff_off;
    logic [AW1-1:0]    addr_full;
    logic [ADDR_W-1:0] in_addr;

    // page modulo PAGE_COUNT: input is 5 bits, reduced by up to eight subtract steps
    always_comb begin
        page_wrap = {4'b0, s_flash_page};
        for (int i = 0; i < 8; i++) begin
            if (page_wrap >= 9'(PAGE_COUNT)) page_wrap = page_wrap - 9'(PAGE_COUNT);
        end
    end

    // offset below 2*PAGE_BYTES: one compare and subtract
    always_comb begin
        off_wrap = {5'b0, s_page_offset};
        if (off_wrap >= 17'(PAGE_BYTES)) off_wrap = off_wrap - 17'(PAGE_BYTES);
    end

    assign eff_page  = s_fixed_window ? '0 : page_wrap[PAGE_W-1:0];
    assign eff_off   = off_wrap[OFF_W-1:0];
    assign addr_full = AW1'(eff_page) * AW1'(PAGE_BYTES) + AW1'(eff_off);
    assign in_addr   = addr_full[ADDR_W-1:0];

    // autoselect ID code for this offset
    logic [7:0] id_code;
    always_comb begin
        if (s_fixed_window) begin
            if (eff_off == OFF_W'(0))      id_code = ID_MFR;
            else if (eff_off == OFF_W'(1)) id_code = ID_DEV;
            else                           id_code = ID_NONE;
        end else begin
            if (eff_off[7:0] == 8'd0)      id_code = ID_MFR;
            else if (eff_off[7:0] == 8'd1) id_code = ID_DEV;
            else                           id_code = ID_NONE;
        end
    end

    // ------------------------------------------------------------------
    // handshake and command sequencer
    seq_state_t seq_reg, seq_next;
    logic       m_valid_reg, m_valid_next;
    logic       in_fire;

    assign s_ready = (seq_reg == SEQ_RUN) && (!m_valid_reg || m_ready);
    assign in_fire = s_valid && s_ready;

    cmd_state_t cmd_state;
    cmd_act_t   cmd_act;

    pfci_cmd u_cmd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_fire (in_fire && s_operation),
        .cmd_off (eff_off[CMD_OFF_W-1:0]),
        .data    (s_write_byte),
        .state   (cmd_state),
        .act     (cmd_act)
    );

    // ------------------------------------------------------------------
    // flash array
    logic              mem_wr_en, mem_rd_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data, mem_rd_data;

    pfci_store #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (in_addr),
        .rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // working registers
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0] sweep_last_reg, sweep_last_next;
    logic [8:0]        find_rem_reg, find_rem_next;
    logic [8:0]        find_base_reg, find_base_next;
    logic [ADDR_W-1:0] prog_addr_reg, prog_addr_next;
    logic [7:0]        prog_data_reg, prog_data_next;
    logic              auto_reg, auto_next;
    logic [7:0]        id_reg, id_next;
    logic [7:0]        m_byte_reg, m_byte_next;

    logic [8:0]        sect_end;
    logic [AW1-1:0]    sect_first, sect_last;

    // sector bounds from the located base page; a short last sector stops at the end
    always_comb begin
        sect_end = find_base_reg + 9'(PAGES_PER_SECTOR);
        if (sect_end > 9'(PAGE_COUNT)) sect_end = 9'(PAGE_COUNT);
        sect_first = AW1'(find_base_reg) * AW1'(PAGE_BYTES);
        sect_last  = AW1'(sect_end) * AW1'(PAGE_BYTES) - AW1'(1);
    end

    // next sequencer state
    always_comb begin
        seq_next = seq_reg;
        case (seq_reg)
            SEQ_SWEEP: begin
                if (sweep_addr_reg == sweep_last_reg) seq_next = SEQ_RUN;
            end
            SEQ_FIND: begin
                if (find_rem_reg < 9'(PAGES_PER_SECTOR)) seq_next = SEQ_SWEEP;
            end
            SEQ_RUN: begin
                if (in_fire) begin
                    if (!s_operation)              seq_next = SEQ_READ;
                    else if (cmd_act.prog)         seq_next = SEQ_PROG;
                    else if (cmd_act.chip_erase)   seq_next = SEQ_SWEEP;
                    else if (cmd_act.sector_erase) seq_next = SEQ_FIND;
                end
            end
            SEQ_READ: seq_next = SEQ_RUN;
            SEQ_PROG: seq_next = SEQ_RUN;
            default:  seq_next = SEQ_RUN;
        endcase
    end

    // memory controls and register updates
    always_comb begin
        mem_wr_en       = 1'b0;
        mem_wr_addr     = sweep_addr_reg;
        mem_wr_data     = ERASED_BYTE;
        mem_rd_en       = 1'b0;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        find_rem_next   = find_rem_reg;
        find_base_next  = find_base_reg;
        prog_addr_next  = prog_addr_reg;
        prog_data_next  = prog_data_reg;
        auto_next       = auto_reg;
        id_next         = id_reg;
        m_byte_next     = m_byte_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        case (seq_reg)
            SEQ_SWEEP: begin
                mem_wr_en       = 1'b1;
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
            end
            SEQ_FIND: begin
                // step down to the sector base one sector a cycle
                if (find_rem_reg >= 9'(PAGES_PER_SECTOR)) begin
                    find_rem_next  = find_rem_reg - 9'(PAGES_PER_SECTOR);
                    find_base_next = find_base_reg + 9'(PAGES_PER_SECTOR);
                end else begin
                    sweep_addr_next = sect_first[ADDR_W-1:0];
                    sweep_last_next = sect_last[ADDR_W-1:0];
                end
            end
            SEQ_RUN: begin
                if (in_fire) begin
                    if (!s_operation) begin
                        mem_rd_en = 1'b1;
                        auto_next = (cmd_state == CMD_AUTOSELECT);
                        id_next   = id_code;
                    end else if (cmd_act.prog) begin
                        mem_rd_en      = 1'b1;
                        prog_addr_next = in_addr;
                        prog_data_next = s_write_byte;
                    end else if (cmd_act.chip_erase) begin
                        sweep_addr_next = '0;
                        sweep_last_next = LAST_ADDR;
                    end else if (cmd_act.sector_erase) begin
                        find_rem_next  = 9'(eff_page);
                        find_base_next = '0;
                    end
                end
            end
            SEQ_READ: begin
                m_valid_next = 1'b1;
                m_byte_next  = auto_reg ? id_reg : mem_rd_data;
            end
            SEQ_PROG: begin
                // programming only clears bits
                mem_wr_en   = 1'b1;
                mem_wr_addr = prog_addr_reg;
                mem_wr_data = mem_rd_data & prog_data_reg;
            end
            default: begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= SEQ_SWEEP;
            sweep_addr_reg <= '0;
            sweep_last_reg <= LAST_ADDR;
            m_valid_reg    <= 1'b0;
        end else begin
            seq_reg        <= seq_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        find_rem_reg  <= find_rem_next;
        find_base_reg <= find_base_next;
        prog_addr_reg <= prog_addr_next;
        prog_data_reg <= prog_data_next;
        auto_reg      <= auto_next;
        id_reg        <= id_next;
        m_byte_reg    <= m_byte_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_read_byte = m_byte_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pfci_checker.sv =====
// Port-level assertions for the paged flash command interface, bound to the top level.
`default_nettype none

module pfci_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       s_operation,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_read_byte
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_byte))
        else $error("result word changed or dropped while stalled");

    // the array is being cleared right after reset
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken before the reset clear");

    // an accepted read shows its result after the memory read and the output register
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_operation |=> ##1 m_valid)
        else $error("read word produced no result");

    // a write taken with no result pending never produces a result word
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation && !m_valid |=> !m_valid)
        else $error("write word produced a result");

endmodule

bind paged_flash_command_interface pfci_checker u_pfci_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_operation (s_operation),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_byte (m_read_byte)
);

`default_nettype wire
